// ===== rtl/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types, sizes and helpers for the PPG Bayer demosaic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppg_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 16384;
  localparam int unsigned MinSize   = 9;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned RawLines  = 6;
  localparam int unsigned GrnLines  = 2;
  localparam int unsigned RawW      = 16;
  localparam int unsigned GqW       = 18;
  localparam int unsigned GeW       = GqW + RawW;

  localparam logic [31:0] CfaReset    = 32'h9494_9494;
  localparam logic [12:0] WidthReset  = 13'd4096;
  localparam logic [14:0] HeightReset = 15'd3072;

  typedef enum logic [1:0] {
    REG_CFA    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CFA_RED    = 2'd0,
    CFA_GREEN  = 2'd1,
    CFA_BLUE   = 2'd2,
    CFA_GREEN2 = 2'd3
  } cfa_code_e;

  // one green line store entry: green (2 frac bits) over raw
  typedef struct packed {
    logic [GqW-1:0]  gq;
    logic [RawW-1:0] raw;
  } gent_t;

  // position and control beside the window
  typedef struct packed {
    logic             gshift;
    logic             emit;
    logic             done;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
  } pos_t;

  function automatic logic [1:0] cfa_code(input logic [31:0] pat,
                                          input logic [2:0] r, input logic c);
    logic [4:0] sh;
    sh = {r, c, 1'b0};
    return pat[sh +: 2];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppg_ram.sv =====
// ----------------------------------------------------------------------------
// ppg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppg_green.sv =====
// ----------------------------------------------------------------------------
// ppg_green
// Combinational green estimate at the 7x7 window centre.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppg_green
  import ppg_pkg::*;
(
  input  wire logic [RawW-1:0] cx_i [7],
  input  wire logic [RawW-1:0] cy_i [7],
  input  wire logic            is_grn_i,
  output      logic [GqW-1:0]  gq_o
);

  function automatic logic [16:0] ad(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  logic signed [20:0] gx, gy, g, lo, hi;
  logic        [21:0] dx, dy;
  logic        [15:0] a, b;

  always_comb begin
    gx = 21'(($signed({5'd0, cx_i[2]}) + $signed({5'd0, cx_i[3]}) +
              $signed({5'd0, cx_i[4]})) * 2) - $signed({5'd0, cx_i[5]})
         - $signed({5'd0, cx_i[1]});
    gy = 21'(($signed({5'd0, cy_i[2]}) + $signed({5'd0, cy_i[3]}) +
              $signed({5'd0, cy_i[4]})) * 2) - $signed({5'd0, cy_i[5]})
         - $signed({5'd0, cy_i[1]});
    dx = 22'(({5'd0, ad(cx_i[1], cx_i[3])} + {5'd0, ad(cx_i[5], cx_i[3])}
              + {5'd0, ad(cx_i[2], cx_i[4])}) * 3)
       + 22'(({5'd0, ad(cx_i[6], cx_i[4])} + {5'd0, ad(cx_i[0], cx_i[2])}) * 2);
    dy = 22'(({5'd0, ad(cy_i[1], cy_i[3])} + {5'd0, ad(cy_i[5], cy_i[3])}
              + {5'd0, ad(cy_i[2], cy_i[4])}) * 3)
       + 22'(({5'd0, ad(cy_i[6], cy_i[4])} + {5'd0, ad(cy_i[0], cy_i[2])}) * 2);
    if (dx > dy) begin
      g = gy; a = cy_i[2]; b = cy_i[4];
    end else begin
      g = gx; a = cx_i[2]; b = cx_i[4];
    end
    lo = $signed({3'd0, ((a < b) ? a : b), 2'b00});
    hi = $signed({3'd0, ((a < b) ? b : a), 2'b00});
    if (g > hi) g = hi;
    if (g < lo) g = lo;
    gq_o = is_grn_i ? {cx_i[3], 2'b00} : g[GqW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/ppg_color.sv =====
// ----------------------------------------------------------------------------
// ppg_color
// Combinational red/blue by colour difference over the 3x3 green window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppg_color
  import ppg_pkg::*;
(
  input  wire gent_t              gw_i [3][3],
  input  wire logic [1:0]         k_i,
  input  wire logic [1:0]         kn_i,
  output      logic signed [21:0] red_o,
  output      logic signed [21:0] blue_o,
  output      logic [19:0]        green_o
);

  function automatic logic signed [21:0] xq(input gent_t e);
    return $signed({4'd0, e.raw, 2'b00});
  endfunction
  function automatic logic signed [21:0] gv(input gent_t e);
    return $signed({4'd0, e.gq});
  endfunction
  function automatic logic signed [21:0] ab(input logic signed [21:0] v);
    return (v < 0) ? -v : v;
  endfunction

  logic signed [21:0] gc, d1, d2, g1, g2, ver, hor, dia, own;

  always_comb begin
    gc  = gv(gw_i[1][1]);
    g1  = 22'(xq(gw_i[0][0]) + xq(gw_i[2][2]) + 2 * gc - gv(gw_i[0][0])
              - gv(gw_i[2][2]));
    g2  = 22'(xq(gw_i[0][2]) + xq(gw_i[2][0]) + 2 * gc - gv(gw_i[0][2])
              - gv(gw_i[2][0]));
    d1  = ab(xq(gw_i[0][0]) - xq(gw_i[2][2])) + ab(gv(gw_i[0][0]) - gc)
        + ab(gv(gw_i[2][2]) - gc);
    d2  = ab(xq(gw_i[0][2]) - xq(gw_i[2][0])) + ab(gv(gw_i[0][2]) - gc)
        + ab(gv(gw_i[2][0]) - gc);
    if (d1 > d2) dia = 22'(2 * g2);
    else if (d1 < d2) dia = 22'(2 * g1);
    else dia = g1 + g2;
    ver = 22'(2 * (xq(gw_i[0][1]) + xq(gw_i[2][1]) + 2 * gc - gv(gw_i[0][1])
                   - gv(gw_i[2][1])));
    hor = 22'(2 * (xq(gw_i[1][0]) + xq(gw_i[1][2]) + 2 * gc - gv(gw_i[1][0])
                   - gv(gw_i[1][2])));
    own = 22'(4 * xq(gw_i[1][1]));
    green_o = {gw_i[1][1].gq, 2'b00};
    if (k_i[0]) begin
      if (kn_i == CFA_RED) begin
        blue_o = ver; red_o = hor;
      end else begin
        red_o = ver; blue_o = hor;
      end
    end else if (k_i == CFA_RED) begin
      red_o = own; blue_o = dia;
    end else begin
      blue_o = own; red_o = dia;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppg_bayer_demosaic.sv =====
// ----------------------------------------------------------------------------
// ppg_bayer_demosaic
// PPG Bayer demosaic: line stores, 7x7 raw and 3x3 green windows, one pixel
// per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// a result passes the s1 registers, the raw window, the green window and the output register
// throughput: one sample per cycle while the output is not stalled; the line store read/write port sets it
// reset: counters, windows and valid bits clear, config takes its defaults; line stores are not cleared
// a stall on the output holds the whole pipeline
`timescale 1ns / 1ps
`default_nettype none

module ppg_bayer_demosaic
  import ppg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [15:0]        sample_i,
  input  wire logic               start_of_frame_i,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [21:0] red_o,
  output      logic [19:0]        green_o,
  output      logic signed [21:0] blue_o,
  output      logic [13:0]        out_row_o,
  output      logic [11:0]        out_col_o,
  output      logic               frame_done_o
);

  logic [31:0] cfa_q;
  logic [12:0] width_q;
  logic [14:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfa_q <= CfaReset; width_q <= WidthReset; height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CFA:    cfa_q    <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[12:0];
        REG_HEIGHT: height_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // pipeline: s0 = accepted beat (line read issued), then the raw window, the green window and the output
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic [13:0] w;
  always_comb begin
    w = {1'b0, width_q};
    if (w < 14'(MinSize))  w = 14'(MinSize);
    if (w > 14'(MaxWidth)) w = 14'(MaxWidth);
  end
  // height may be 16384, so compare in 15 bits
  logic [14:0] hh;
  always_comb begin
    hh = height_q;
    if (hh < 15'(MinSize))   hh = 15'(MinSize);
    if (hh > 15'(MaxHeight)) hh = 15'(MaxHeight);
  end

  logic [14:0] row_q, r, r_nxt;
  logic [12:0] col_q, c;
  logic [13:0] c_nxt;

  always_comb begin
    r = row_q; c = col_q;
    if (start_of_frame_i) begin
      r = '0; c = '0;
    end
    if ({1'b0, c} >= w) begin
      c = '0; r = r + 15'd1;
    end
    if (r >= hh) r = '0;
    c_nxt = {1'b0, c} + 14'd1;
    r_nxt = r;
    if (c_nxt >= w) begin
      c_nxt = '0; r_nxt = r + 15'd1;
      if (r_nxt >= hh) r_nxt = '0;
    end
  end

  logic acc;
  assign acc = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0;
    end else if (acc) begin
      row_q <= r_nxt; col_q <= c_nxt[12:0];
    end
  end

  // raw line store: six banks packed in one word, read-modify-write per column
  logic [RawLines*RawW-1:0] rl_rd, rl_wr;
  logic [ColW-1:0]          c1_q, c2_q;
  logic [RawW-1:0]          s1_q;
  logic                     v1_q;
  logic [14:0]              r1_q;
  logic                     rd_fwd_q;
  logic [RawLines*RawW-1:0] rl_last_q, rl_col;

  ppg_ram #(.Width(RawLines*RawW), .Depth(MaxWidth)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q && adv),
    .waddr_i (c1_q),
    .wdata_i (rl_wr),
    .re_i    (adv),
    .raddr_i (c[ColW-1:0]),
    .rdata_o (rl_rd)
  );

  // a repeated column is forwarded from the last write
  assign rl_col = rd_fwd_q ? rl_last_q : rl_rd;
  assign rl_wr  = {rl_col[(RawLines-1)*RawW-1:0], s1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q      <= c[ColW-1:0];
      r1_q      <= r;
      s1_q      <= sample_i;
      rd_fwd_q  <= v1_q && (c1_q == c[ColW-1:0]);
      rl_last_q <= rl_wr;
      c2_q      <= c1_q;
    end
  end

  // raw window, column 6 is newest; row 6 is the current sample
  logic [RawW-1:0] rw_q [7][7];
  logic [RawW-1:0] colv [7];
  always_comb begin
    colv[6] = s1_q;
    for (int k = 0; k < RawLines; k++) begin
      colv[5-k] = rl_col[k*RawW +: RawW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) for (int j = 0; j < 7; j++) rw_q[i][j] <= '0;
    end else if (adv && v1_q) begin
      for (int i = 0; i < 7; i++) begin
        for (int j = 0; j < 6; j++) rw_q[i][j] <= rw_q[i][j+1];
        rw_q[i][6] <= colv[i];
      end
    end
  end

  // stage 2: green estimate on the updated raw window
  pos_t p2_q;
  logic [14:0] r2_q;
  logic [RawW-1:0] cx [7], cy [7];
  logic [GqW-1:0]  gq_new;
  logic [1:0]      kg;
  logic [14:0]     rg;
  always_comb begin
    for (int j = 0; j < 7; j++) begin
      cx[j] = rw_q[3][j]; cy[j] = rw_q[j][3];
    end
    rg = r2_q - 15'd3;
    kg = cfa_code(cfa_q, rg[2:0], c2_q[0] ^ 1'b1);
  end

  ppg_green u_green (
    .cx_i     (cx),
    .cy_i     (cy),
    .is_grn_i (kg[0]),
    .gq_o     (gq_new)
  );

  logic v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q         <= r1_q;
      p2_q.gshift  <= c1_q >= ColW'(3);
      p2_q.emit    <= (r1_q >= 15'd8) && (c1_q >= ColW'(8));
      p2_q.done    <= (r1_q == hh - 15'd1) && ({2'b0, c1_q} == w - 14'd1);
      p2_q.row     <= 14'(r1_q - 15'd4);
      p2_q.col     <= c1_q - ColW'(4);
    end
  end

  // green line store: two lines at column gc; read address the centre column
  gent_t entry, gl0, gl1, gl_last0_q, gl_last1_q;
  logic [2*GeW-1:0] gl_rd;
  logic [ColW-1:0]  gc1, gc2_q;
  logic             gfwd_q;
  assign gc1   = c1_q - ColW'(3);
  assign entry = '{gq: gq_new, raw: rw_q[3][3]};
  assign gl0   = gfwd_q ? gl_last0_q : gent_t'(gl_rd[GeW-1:0]);
  assign gl1   = gfwd_q ? gl_last1_q : gent_t'(gl_rd[2*GeW-1:GeW]);

  logic gwe;
  assign gwe = v2_q && p2_q.gshift && adv;

  ppg_ram #(.Width(2*GeW), .Depth(MaxWidth)) u_grn_ram (
    .clk_i   (clk_i),
    .we_i    (gwe),
    .waddr_i (gc2_q),
    .wdata_i ({gl0, entry}),
    .re_i    (adv),
    .raddr_i (gc1),
    .rdata_o (gl_rd)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gc2_q      <= gc1;
      gfwd_q     <= gwe && (gc2_q == gc1);
      gl_last0_q <= entry;
      gl_last1_q <= gl0;
    end
  end

  // green window
  gent_t gw_q [3][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) gw_q[i][j] <= '0;
    end else if (gwe) begin
      for (int i = 0; i < 3; i++) begin
        gw_q[i][0] <= gw_q[i][1];
        gw_q[i][1] <= gw_q[i][2];
      end
      gw_q[0][2] <= gl1;
      gw_q[1][2] <= gl0;
      gw_q[2][2] <= entry;
    end
  end

  // stage 3: colour on the updated green window
  pos_t p3_q;
  logic v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q && p2_q.emit;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) p3_q <= p2_q;
  end

  logic [1:0] k3, kn3;
  logic [ColW-1:0] cn3;
  logic signed [21:0] red_d, blue_d;
  logic [19:0] green_d;
  assign cn3 = p3_q.col + ColW'(1);
  assign k3  = cfa_code(cfa_q, p3_q.row[2:0], p3_q.col[0]);
  assign kn3 = cfa_code(cfa_q, p3_q.row[2:0], cn3[0]);

  ppg_color u_color (
    .gw_i    (gw_q),
    .k_i     (k3),
    .kn_i    (kn3),
    .red_o   (red_d),
    .blue_o  (blue_d),
    .green_o (green_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_o        <= red_d;
      green_o      <= green_d;
      blue_o       <= blue_d;
      out_row_o    <= p3_q.row;
      out_col_o    <= p3_q.col;
      frame_done_o <= p3_q.done;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready not tied to output stage");
  a_gwin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v3_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== tb/ppg_bayer_demosaic_test.sv =====
// ----------------------------------------------------------------------------
// ppg_bayer_demosaic_test
// Streams raw Bayer frames of several sizes and patterns through the PPG
// demosaic and checks every emitted pixel against a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppg_bayer_demosaic_test;
  import ppg_pkg::*;

  typedef struct packed {
    logic [21:0] red;
    logic [19:0] green;
    logic [21:0] blue;
    logic [13:0] row;
    logic [11:0] col;
    logic        done;
  } pixel_t;

  class demosaic_scoreboard;
    logic [31:0] pattern;
    int unsigned width, height, row_pos, col_pos;
    logic [15:0] raw_lines[6][4096];
    logic [33:0] grn_lines[2][4096];
    int          raw_win[7][7];
    logic [33:0] grn_win[3][3];
    pixel_t      pending[$];
    int          errors;

    function new();
      pattern = CfaReset;
      width = 4096;
      height = 3072;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
      for (int k = 0; k < 4096; k++) begin
        for (int i = 0; i < 6; i++) raw_lines[i][k] = '0;
        grn_lines[0][k] = '0;
        grn_lines[1][k] = '0;
      end
      for (int i = 0; i < 7; i++) for (int j = 0; j < 7; j++) raw_win[i][j] = 0;
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) grn_win[i][j] = '0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_CFA:    pattern = value;
        REG_WIDTH:  width = value[12:0];
        REG_HEIGHT: height = value[14:0];
        default: ;
      endcase
    endfunction

    function cfa_code_e colour(int unsigned r, int unsigned c);
      return cfa_code_e'(pattern[(((r & 7) << 1) + (c & 1)) << 1 +: 2]);
    endfunction

    function int absdiff(int a, int b);
      return a > b ? a - b : b - a;
    endfunction

    function int gval(int i, int j);
      return int'(grn_win[i][j][33:16]);
    endfunction

    function int rval(int i, int j);
      return int'(grn_win[i][j][15:0]) * 4;
    endfunction

    // green at the raw window centre, 2 frac bits
    function int centre_green(int unsigned r, int unsigned c);
      int pc, gx, gy, dx, dy, g, a, b, lo, hi;
      cfa_code_e k;
      pc = raw_win[3][3];
      k = colour(r, c);
      if (k != CFA_RED && k != CFA_BLUE) return pc * 4;
      gx = (raw_win[3][2] + pc + raw_win[3][4]) * 2 - raw_win[3][5] - raw_win[3][1];
      dx = (absdiff(raw_win[3][1], pc) + absdiff(raw_win[3][5], pc) +
            absdiff(raw_win[3][2], raw_win[3][4])) * 3 +
           (absdiff(raw_win[3][6], raw_win[3][4]) + absdiff(raw_win[3][0], raw_win[3][2])) * 2;
      gy = (raw_win[2][3] + pc + raw_win[4][3]) * 2 - raw_win[5][3] - raw_win[1][3];
      dy = (absdiff(raw_win[1][3], pc) + absdiff(raw_win[5][3], pc) +
            absdiff(raw_win[2][3], raw_win[4][3])) * 3 +
           (absdiff(raw_win[6][3], raw_win[4][3]) + absdiff(raw_win[0][3], raw_win[2][3])) * 2;
      if (dx > dy) begin
        g = gy; a = raw_win[2][3]; b = raw_win[4][3];
      end else begin
        g = gx; a = raw_win[3][2]; b = raw_win[3][4];
      end
      lo = (a < b ? a : b) * 4;
      hi = (a < b ? b : a) * 4;
      if (g > hi) g = hi;
      if (g < lo) g = lo;
      return g;
    endfunction

    function int diff_guess(int ai, int aj, int bi, int bj);
      return rval(ai, aj) + rval(bi, bj) + 2 * gval(1, 1) - gval(ai, aj) - gval(bi, bj);
    endfunction

    function int diag_guess();
      int d1, d2, g1, g2;
      d1 = absdiff(rval(0, 0), rval(2, 2)) + absdiff(gval(0, 0), gval(1, 1)) +
           absdiff(gval(2, 2), gval(1, 1));
      d2 = absdiff(rval(0, 2), rval(2, 0)) + absdiff(gval(0, 2), gval(1, 1)) +
           absdiff(gval(2, 0), gval(1, 1));
      g1 = diff_guess(0, 0, 2, 2);
      g2 = diff_guess(0, 2, 2, 0);
      if (d1 > d2) return 2 * g2;
      if (d1 < d2) return 2 * g1;
      return g1 + g2;
    endfunction

    function void note_sample(logic [15:0] s, logic sof);
      int unsigned w, h, r, c;
      int          colv[7];
      int          q, red, blue;
      logic [33:0] entry, old0, old1;
      cfa_code_e   k;
      pixel_t      px;
      w = width < MinSize ? MinSize : (width > MaxWidth ? MaxWidth : width);
      h = height < MinSize ? MinSize : (height > MaxHeight ? MaxHeight : height);
      r = row_pos;
      c = col_pos;
      if (sof) begin
        r = 0; c = 0;
      end
      if (c >= w) begin
        c = 0; r++;
      end
      if (r >= h) r = 0;
      colv[6] = s;
      for (int i = 0; i < 6; i++) colv[5 - i] = raw_lines[i][c];
      for (int i = 5; i > 0; i--) raw_lines[i][c] = raw_lines[i - 1][c];
      raw_lines[0][c] = s;
      for (int i = 0; i < 7; i++) begin
        for (int j = 0; j < 6; j++) raw_win[i][j] = raw_win[i][j + 1];
        raw_win[i][6] = colv[i];
      end
      if (c >= 3) begin
        q = centre_green(r - 3, c - 3);
        entry = {q[17:0], raw_win[3][3][15:0]};
        old0 = grn_lines[0][c - 3];
        old1 = grn_lines[1][c - 3];
        for (int i = 0; i < 3; i++) begin
          grn_win[i][0] = grn_win[i][1];
          grn_win[i][1] = grn_win[i][2];
        end
        grn_win[0][2] = old1;
        grn_win[1][2] = old0;
        grn_win[2][2] = entry;
        grn_lines[1][c - 3] = old0;
        grn_lines[0][c - 3] = entry;
      end
      col_pos = c + 1;
      row_pos = r;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
      if (r < 8 || c < 8) return;
      k = colour(r - 4, c - 4);
      if (k == CFA_GREEN || k == CFA_GREEN2) begin
        if (colour(r - 4, c - 3) == CFA_RED) begin
          blue = 2 * diff_guess(0, 1, 2, 1);
          red = 2 * diff_guess(1, 0, 1, 2);
        end else begin
          red = 2 * diff_guess(0, 1, 2, 1);
          blue = 2 * diff_guess(1, 0, 1, 2);
        end
      end else if (k == CFA_RED) begin
        red = rval(1, 1) * 4;
        blue = diag_guess();
      end else begin
        blue = rval(1, 1) * 4;
        red = diag_guess();
      end
      q = gval(1, 1) * 4;
      px.red = red[21:0];
      px.green = q[19:0];
      px.blue = blue[21:0];
      px.row = 14'(r - 4);
      px.col = 12'(c - 4);
      px.done = (r == h - 1 && c == w - 1);
      pending.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel %p", $time, got);
        return;
      end
      exp = pending.pop_front();
      if (got.red !== exp.red) begin
        errors++;
        $display("%0t: red exp %h got %h", $time, exp.red, got.red);
      end
      if (got.green !== exp.green) begin
        errors++;
        $display("%0t: green exp %h got %h", $time, exp.green, got.green);
      end
      if (got.blue !== exp.blue) begin
        errors++;
        $display("%0t: blue exp %h got %h", $time, exp.blue, got.blue);
      end
      if (got.row !== exp.row) begin
        errors++;
        $display("%0t: row exp %0d got %0d", $time, exp.row, got.row);
      end
      if (got.col !== exp.col) begin
        errors++;
        $display("%0t: col exp %0d got %0d", $time, exp.col, got.col);
      end
      if (got.done !== exp.done) begin
        errors++;
        $display("%0t: frame_done exp %b got %b", $time, exp.done, got.done);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_i = '0;
  logic        start_of_frame_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_CFA;
  logic [31:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [21:0] red_o, blue_o;
  logic [19:0] green_o;
  logic [13:0] out_row_o;
  logic [11:0] out_col_o;
  logic        frame_done_o;

  demosaic_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  no_gaps = 0;

  ppg_bayer_demosaic u_dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // starts and ends at a falling edge
  task automatic send_sample(input logic [15:0] s, input logic sof);
    int g;
    in_valid_i = 1'b1;
    sample_i = s;
    start_of_frame_i = sof;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s, sof);
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic setup(input logic [31:0] pat, input int w, input int h);
    drain();
    write_reg(REG_CFA, pat);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // style: 0 random, 1 all max, 2 all zero, 3 checker, 4 noisy ramp
  task automatic send_frame(input int w, input int h, input int style, input bit sof);
    logic [15:0] s;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (style)
          1: s = 16'hffff;
          2: s = 16'h0000;
          3: s = ((r + c) & 1) ? 16'hffff : 16'h0000;
          4: s = 16'(r * 300 + c * 200 + $urandom_range(0, 7));
          default: s = 16'($urandom);
        endcase
        send_sample(s, sof && r == 0 && c == 0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel({red_o, green_o, blue_o, out_row_o, out_col_o, frame_done_o});
    if (idle_cycles > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int g;
    @(negedge clk_i);
    forever begin
      out_ready_i = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i = 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  end

  initial begin
    int w, h, items;
    logic [31:0] pat;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, flat frames give gradient ties, checker gives max steps
    setup(CfaReset, 9, 9);
    send_frame(9, 9, 1, 1);
    send_frame(9, 9, 2, 1);
    setup(32'h4949_4949, 10, 10);
    send_frame(10, 10, 3, 1);
    send_frame(10, 10, 0, 1);
    // frame continues by wrap, no start marker
    send_frame(10, 10, 4, 0);
    // sizes below the minimum saturate
    setup(32'h1b1b_1b1b, 0, 3);
    send_frame(9, 9, 0, 1);
    // broken frame: restart part way through
    send_frame(9, 4, 0, 1);
    send_frame(9, 9, 3, 1);
    // odd pattern: every code green, then every code red
    setup(32'hffff_ffff, 11, 9);
    send_frame(11, 9, 0, 1);
    setup(32'h0000_0000, 11, 9);
    send_frame(11, 9, 0, 1);
    setup(32'haaaa_aaaa, 9, 11);
    send_frame(9, 11, 3, 1);

    items = 0;
    while (items < 500) begin
      w = $urandom_range(9, 16);
      h = $urandom_range(9, 13);
      case ($urandom_range(0, 3))
        0: pat = 32'h9494_9494;
        1: pat = 32'h6161_6161;
        2: pat = $urandom;
        default: pat = 32'h1616_1616;
      endcase
      setup(pat, w, h);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2)) begin
        send_frame(w, h, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4), 1);
        items += w * h;
      end
      no_gaps = 0;
    end

    // width and height beyond the size maxima saturate
    no_gaps = 1;
    setup(32'h9494_9494, 13'h1fff, 9);
    // 200 beats along the first line, no wrap
    send_frame(40, 5, 0, 1);
    setup(32'h4949_4949, 9, 15'h7fff);
    send_frame(9, 20, 0, 1);
    no_gaps = 0;

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppg_pkg.sv
rtl/ppg_ram.sv
rtl/ppg_green.sv
rtl/ppg_color.sv
rtl/ppg_bayer_demosaic.sv
tb/ppg_bayer_demosaic_test.sv
